// ===== src/qfr_pkg.sv =====
// qfr_pkg: shared constants for the rotation matrix to quaternion block
// default word and fraction widths, and the codes for the four root cases
// no dependencies
package qfr_pkg;

   // default number format, signed Q2.30
   localparam int QFR_WORD_BITS = 32;
   localparam int QFR_FRAC_BITS = 30;

   // which component comes from the square root
   localparam logic [1:0] CASE_W = 2'd0;
   localparam logic [1:0] CASE_X = 2'd1;
   localparam logic [1:0] CASE_Y = 2'd2;
   localparam logic [1:0] CASE_Z = 2'd3;

endpackage

// ===== src/qfr_if.sv =====
// qfr_if: valid/ready channels of the rotation matrix to quaternion block
// request carries the nine matrix entries, response the quaternion
// depends on qfr_pkg for the default word width
interface qfr_req_if #(parameter int WORD_BITS = qfr_pkg::QFR_WORD_BITS);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] r0c0;
   logic signed [WORD_BITS-1:0] r0c1;
   logic signed [WORD_BITS-1:0] r0c2;
   logic signed [WORD_BITS-1:0] r1c0;
   logic signed [WORD_BITS-1:0] r1c1;
   logic signed [WORD_BITS-1:0] r1c2;
   logic signed [WORD_BITS-1:0] r2c0;
   logic signed [WORD_BITS-1:0] r2c1;
   logic signed [WORD_BITS-1:0] r2c2;

   modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                   input ready);
   modport sink   (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                   output ready);
endinterface

interface qfr_rsp_if #(parameter int WORD_BITS = qfr_pkg::QFR_WORD_BITS);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] quat_x;
   logic signed [WORD_BITS-1:0] quat_y;
   logic signed [WORD_BITS-1:0] quat_z;
   logic signed [WORD_BITS-1:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== src/quat_from_rotation_matrix.sv =====
// quat_from_rotation_matrix: 3x3 rotation matrix to unit quaternion, pipelined
// depends on qfr_pkg (case codes, defaults) and qfr_if (request and response channels)
//
// usage
//   req_chan carries one request: the nine matrix entries r0c0..r2c2, signed
//   fixed point with FRAC_BITS fraction bits; rsp_chan returns quat_x, quat_y,
//   quat_z, quat_w in the same format, one response per request, in order.
//   both channels are valid/ready; a transfer happens on a clock edge with both high
// structure and throughput
//   SW = (WORD_BITS + FRAC_BITS) / 2 root bits, QB = WORD_BITS + 1 quotient bits;
//   the square root retires one root bit per stage and the three dividers one
//   quotient bit per stage
//   one request is accepted every cycle while the response side takes data
// reset
//   synchronous active-high reset clears all valid bits; the block keeps no
//   other state
// stall
//   when the response is held (valid high, ready low) the whole pipeline
//   freezes and req_chan.ready drops; nothing is lost or repeated
module quat_from_rotation_matrix #(
   parameter int WORD_BITS = qfr_pkg::QFR_WORD_BITS,
   parameter int FRAC_BITS = qfr_pkg::QFR_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   qfr_req_if.sink    req_chan,
   qfr_rsp_if.source  rsp_chan
);
   import qfr_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int SW   = (W + F) / 2;
   localparam int NW   = 2 * SW;
   localparam int RW   = SW + 2;
   localparam int QB   = W + 1;
   localparam int NUMW = W + F - 1;
   localparam int XW   = W + F + SW;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  =
      (F >= W - 1) ? WMAX : (W'(1) << F);

   // saturating add and subtract on the word
   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [W:0] sum;
      sum = {a[W-1], a} + {b[W-1], b};
      if (sum[W] != sum[W-1]) sat_add = sum[W] ? WMIN : WMAX;
      else                    sat_add = sum[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [W:0] dif;
      dif = {a[W-1], a} - {b[W-1], b};
      if (dif[W] != dif[W-1]) sat_sub = dif[W] ? WMIN : WMAX;
      else                    sat_sub = dif[W-1:0];
   endfunction

   // final quotient: sign, zero and overflow handling
   function automatic logic signed [W-1:0] lane_result(input logic [QB-1:0] q,
                                                       input logic neg,
                                                       input logic zero,
                                                       input logic ovf);
      logic [QB-1:0] neg_q;
      neg_q = -q;
      if (zero)                               lane_result = '0;
      else if (!neg && (ovf || q > QB'(WMAX))) lane_result = WMAX;
      else if (!neg)                          lane_result = W'(q);
      else if (ovf || q > QB'(WMAX) + QB'(1)) lane_result = WMIN;
      else                                    lane_result = W'(neg_q);
   endfunction

   logic adv;

   // global pipeline enable, frozen while the response is held
   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- stage a: input register ----------------
   logic                in_vld_ff;
   logic signed [W-1:0] xx_ff, xy_ff, xz_ff, yx_ff, yy_ff, yz_ff, zx_ff, zy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff <= req_chan.r0c0;
         xy_ff <= req_chan.r0c1;
         xz_ff <= req_chan.r0c2;
         yx_ff <= req_chan.r1c0;
         yy_ff <= req_chan.r1c1;
         yz_ff <= req_chan.r1c2;
         zx_ff <= req_chan.r2c0;
         zy_ff <= req_chan.r2c1;
         zz_ff <= req_chan.r2c2;
      end
   end

   // ---------------- stage b: first sums and diagonal compares ----------------
   logic                b_vld_ff;
   logic signed [W-1:0] b_sxy_ff, b_ox_ff, b_oy_ff, b_oz_ff, b_xx_ff, b_yy_ff, b_zz_ff;
   logic signed [W-1:0] b_dzy_ff, b_dxz_ff, b_dyx_ff, b_syx_ff, b_sxz_ff, b_szy_ff;
   logic                b_gxy_ff, b_gxz_ff, b_gyz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         b_sxy_ff <= sat_add(xx_ff, yy_ff);
         b_ox_ff  <= sat_add(ONE, xx_ff);
         b_oy_ff  <= sat_add(ONE, yy_ff);
         b_oz_ff  <= sat_add(ONE, zz_ff);
         b_xx_ff  <= xx_ff;
         b_yy_ff  <= yy_ff;
         b_zz_ff  <= zz_ff;
         b_dzy_ff <= sat_sub(zy_ff, yz_ff);
         b_dxz_ff <= sat_sub(xz_ff, zx_ff);
         b_dyx_ff <= sat_sub(yx_ff, xy_ff);
         b_syx_ff <= sat_add(yx_ff, xy_ff);
         b_sxz_ff <= sat_add(xz_ff, zx_ff);
         b_szy_ff <= sat_add(zy_ff, yz_ff);
         b_gxy_ff <= xx_ff > yy_ff;
         b_gxz_ff <= xx_ff > zz_ff;
         b_gyz_ff <= yy_ff > zz_ff;
      end
   end

   // ---------------- stage c: trace and partial radicands ----------------
   logic                c_vld_ff;
   logic signed [W-1:0] c_t_ff, c_rx_ff, c_ry_ff, c_rz_ff, c_yy_ff, c_zz_ff;
   logic signed [W-1:0] c_dzy_ff, c_dxz_ff, c_dyx_ff, c_syx_ff, c_sxz_ff, c_szy_ff;
   logic                c_gxy_ff, c_gxz_ff, c_gyz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_t_ff   <= sat_add(b_sxy_ff, b_zz_ff);
         c_rx_ff  <= sat_sub(b_ox_ff, b_yy_ff);
         c_ry_ff  <= sat_sub(b_oy_ff, b_xx_ff);
         c_rz_ff  <= sat_sub(b_oz_ff, b_xx_ff);
         c_yy_ff  <= b_yy_ff;
         c_zz_ff  <= b_zz_ff;
         c_dzy_ff <= b_dzy_ff;
         c_dxz_ff <= b_dxz_ff;
         c_dyx_ff <= b_dyx_ff;
         c_syx_ff <= b_syx_ff;
         c_sxz_ff <= b_sxz_ff;
         c_szy_ff <= b_szy_ff;
         c_gxy_ff <= b_gxy_ff;
         c_gxz_ff <= b_gxz_ff;
         c_gyz_ff <= b_gyz_ff;
      end
   end

   // ---------------- stage d: case select, radicand, dividends ----------------
   logic [1:0]          d_case_in;
   logic signed [W-1:0] d_rad_in;
   logic [NW-1:0]       d_n_in;
   logic signed [W-1:0] d_d_in [3];

   always_comb begin
      if (!c_t_ff[W-1])            d_case_in = CASE_W;
      else if (c_gxy_ff && c_gxz_ff) d_case_in = CASE_X;
      else if (c_gyz_ff)           d_case_in = CASE_Y;
      else                         d_case_in = CASE_Z;

      unique case (d_case_in)
         CASE_W: begin
            d_rad_in  = sat_add(c_t_ff, ONE);
            d_d_in[0] = c_dzy_ff;
            d_d_in[1] = c_dxz_ff;
            d_d_in[2] = c_dyx_ff;
         end
         CASE_X: begin
            d_rad_in  = sat_sub(c_rx_ff, c_zz_ff);
            d_d_in[0] = c_syx_ff;
            d_d_in[1] = c_sxz_ff;
            d_d_in[2] = c_dzy_ff;
         end
         CASE_Y: begin
            d_rad_in  = sat_sub(c_ry_ff, c_zz_ff);
            d_d_in[0] = c_syx_ff;
            d_d_in[1] = c_szy_ff;
            d_d_in[2] = c_dxz_ff;
         end
         default: begin
            d_rad_in  = sat_sub(c_rz_ff, c_yy_ff);
            d_d_in[0] = c_sxz_ff;
            d_d_in[1] = c_szy_ff;
            d_d_in[2] = c_dyx_ff;
         end
      endcase

      // non-positive radicand gives a zero root
      if (d_rad_in[W-1] || d_rad_in == '0) d_n_in = '0;
      else                                 d_n_in = NW'($unsigned(d_rad_in)) << F;
   end

   // ---------------- square root stages, one root bit each ----------------
   logic                sq_vld_ff  [SW+1];
   logic [RW-1:0]       sq_rem_ff  [SW+1];
   logic [SW-1:0]       sq_root_ff [SW+1];
   logic [NW-1:0]       sq_rad_ff  [SW+1];
   logic [1:0]          sq_case_ff [SW+1];
   logic signed [W-1:0] sq_d_ff    [SW+1][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_rad_ff[0]  <= d_n_in;
         sq_case_ff[0] <= d_case_in;
         sq_d_ff[0]    <= d_d_in;
      end
   end

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [RW-1:0] rem_pre;
      logic [RW-1:0] trial;
      logic          ge;

      assign rem_pre = {sq_rem_ff[k][RW-3:0], sq_rad_ff[k][NW-1 -: 2]};
      assign trial   = {sq_root_ff[k], 2'b01};
      assign ge      = rem_pre >= trial;

      // restoring step: try the next root bit
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k+1]  <= ge ? rem_pre - trial : rem_pre;
            sq_root_ff[k+1] <= {sq_root_ff[k][SW-2:0], ge};
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][NW-3:0], 2'b00};
            sq_case_ff[k+1] <= sq_case_ff[k];
            sq_d_ff[k+1]    <= sq_d_ff[k];
         end
      end
   end

   // ---------------- divider prep: magnitude, overflow, zero ----------------
   logic          dv_vld_ff  [QB+1];
   logic [SW-1:0] dv_s_ff    [QB+1];
   logic [1:0]    dv_case_ff [QB+1];
   logic [SW-1:0] dv_rem_ff  [QB+1][3];
   logic [QB-1:0] dv_q_ff    [QB+1][3];
   logic [QB-1:0] dv_lo_ff   [QB+1][3];
   logic          dv_neg_ff  [QB+1][3];
   logic          dv_zero_ff [QB+1][3];
   logic          dv_ovf_ff  [QB+1][3];

   logic [SW-1:0] s_root;
   assign s_root = sq_root_ff[SW];

   for (genvar l = 0; l < 3; l++) begin : g_prep
      logic [W-1:0]    mag;
      logic [NUMW-1:0] num;
      logic [NUMW-QB-1:0] hi;
      logic            ovf;

      assign mag = sq_d_ff[SW][l][W-1] ? -$unsigned(sq_d_ff[SW][l])
                                       : $unsigned(sq_d_ff[SW][l]);
      assign num = {mag, {(F-1){1'b0}}};
      assign hi  = num[NUMW-1:QB];
      assign ovf = XW'(hi) >= XW'(s_root);

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[0][l]  <= SW'(hi);
            dv_q_ff[0][l]    <= '0;
            dv_lo_ff[0][l]   <= num[QB-1:0];
            dv_neg_ff[0][l]  <= sq_d_ff[SW][l][W-1];
            dv_zero_ff[0][l] <= (s_root == '0) || (sq_d_ff[SW][l] == '0);
            dv_ovf_ff[0][l]  <= ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_s_ff[0]    <= s_root;
         dv_case_ff[0] <= sq_case_ff[SW];
      end
   end

   // ---------------- divider stages, one quotient bit per lane each ----------------
   for (genvar j = 0; j < QB; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_s_ff[j+1]    <= dv_s_ff[j];
            dv_case_ff[j+1] <= dv_case_ff[j];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [SW:0] part;
         logic        ge;

         assign part = {dv_rem_ff[j][l], dv_lo_ff[j][l][QB-1]};
         assign ge   = part >= {1'b0, dv_s_ff[j]};

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j+1][l]  <= ge ? SW'(part - {1'b0, dv_s_ff[j]}) : SW'(part);
               dv_q_ff[j+1][l]    <= {dv_q_ff[j][l][QB-2:0], ge};
               dv_lo_ff[j+1][l]   <= {dv_lo_ff[j][l][QB-2:0], 1'b0};
               dv_neg_ff[j+1][l]  <= dv_neg_ff[j][l];
               dv_zero_ff[j+1][l] <= dv_zero_ff[j][l];
               dv_ovf_ff[j+1][l]  <= dv_ovf_ff[j][l];
            end
         end
      end
   end

   // ---------------- output stage: saturate and place components ----------------
   logic                out_vld_ff;
   logic [1:0]          out_case_ff;
   logic signed [W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic signed [W-1:0] lane_in [3];
   logic signed [W-1:0] half_in;
   logic [XW-1:0]       half_ext;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lane_in[l] = lane_result(dv_q_ff[QB][l], dv_neg_ff[QB][l],
                                  dv_zero_ff[QB][l], dv_ovf_ff[QB][l]);
      end
      half_ext = XW'(dv_s_ff[QB] >> 1);
      half_in  = (half_ext > XW'(WMAX)) ? WMAX : W'(half_ext);

      unique case (dv_case_ff[QB])
         CASE_W: begin
            qx_in = lane_in[0]; qy_in = lane_in[1]; qz_in = lane_in[2]; qw_in = half_in;
         end
         CASE_X: begin
            qx_in = half_in; qy_in = lane_in[0]; qz_in = lane_in[1]; qw_in = lane_in[2];
         end
         CASE_Y: begin
            qx_in = lane_in[0]; qy_in = half_in; qz_in = lane_in[1]; qw_in = lane_in[2];
         end
         default: begin
            qx_in = lane_in[0]; qy_in = lane_in[1]; qz_in = half_in; qw_in = lane_in[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff       <= qx_in;
         qy_ff       <= qy_in;
         qz_ff       <= qz_in;
         qw_ff       <= qw_in;
         out_case_ff <= dv_case_ff[QB];
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= SW; k++) sq_vld_ff[k] <= 1'b0;
         for (int j = 0; j <= QB; j++) dv_vld_ff[j] <= 1'b0;
      end else if (adv) begin
         in_vld_ff    <= req_chan.valid;
         b_vld_ff     <= in_vld_ff;
         c_vld_ff     <= b_vld_ff;
         sq_vld_ff[0] <= c_vld_ff;
         for (int k = 0; k < SW; k++) sq_vld_ff[k+1] <= sq_vld_ff[k];
         dv_vld_ff[0] <= sq_vld_ff[SW];
         for (int j = 0; j < QB; j++) dv_vld_ff[j+1] <= dv_vld_ff[j];
         out_vld_ff   <= dv_vld_ff[QB];
      end
   end

   assign rsp_chan.valid  = out_vld_ff;
   assign rsp_chan.quat_x = qx_ff;
   assign rsp_chan.quat_y = qy_ff;
   assign rsp_chan.quat_z = qz_ff;
   assign rsp_chan.quat_w = qw_ff;

   // ---------------- assertions ----------------
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request refused with empty output");

   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SW] |-> sq_rem_ff[SW] <= {1'b0, sq_root_ff[SW], 1'b0})
      else $error("square root remainder out of range");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_vld_ff[0] && !dv_zero_ff[0][0] && !dv_ovf_ff[0][0])
         |-> dv_rem_ff[0][0] < dv_s_ff[0])
      else $error("divider start remainder not below root");

   a_root_part_nonneg: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_case_ff == CASE_W) |-> !qw_ff[W-1])
      else $error("root component negative");

endmodule

// ===== verif/qfr_tb_if.sv =====
`timescale 1ns / 1ps
// testbench-side note: the channel interfaces qfr_req_if and qfr_rsp_if are defined in src/qfr_if.sv
// this file holds the shared quaternion predictor package used by checker and stimulus
// depends on qfr_pkg for widths
package qfr_tb_pkg;
   import qfr_pkg::*;

   typedef logic signed [QFR_WORD_BITS-1:0] word_type;
   typedef struct {
      word_type xx, xy, xz, yx, yy, yz, zx, zy, zz;
   } matrix_type;
   typedef struct {
      word_type x, y, z, w;
   } quat_type;

   localparam longint WMAX = (64'sd1 <<< (QFR_WORD_BITS - 1)) - 1;
   localparam longint WMIN = -WMAX - 1;

   function automatic longint sat(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   // floor(sqrt(r * 2^frac)), zero for non-positive radicand
   function automatic logic [63:0] root_of(longint r);
      logic [127:0] n, c;
      logic [63:0] res;
      if (r <= 0) return 0;
      n = 128'(r) << QFR_FRAC_BITS;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         c = 128'(res | (64'd1 << b));
         if (c * c <= n) res = res | (64'd1 << b);
      end
      return res;
   endfunction

   function automatic longint half_root(logic [63:0] s);
      logic [63:0] h;
      h = s >> 1;
      return (h > 64'(WMAX)) ? WMAX : longint'(h);
   endfunction

   // d * 2^(frac-1) / s, truncated toward zero, saturated
   function automatic longint quotient(longint d, logic [63:0] s);
      logic [127:0] mag, q;
      if (s == 0 || d == 0) return 0;
      mag = (d < 0) ? 128'(-d) : 128'(d);
      q = (mag << (QFR_FRAC_BITS - 1)) / 128'(s);
      if (d < 0) return (q > 128'(WMAX) + 1) ? WMIN : -longint'(q);
      return (q > 128'(WMAX)) ? WMAX : longint'(q);
   endfunction

   function automatic quat_type predict_quat(matrix_type m);
      longint xx, xy, xz, yx, yy, yz, zx, zy, zz, one, tr;
      logic [63:0] s;
      quat_type q;
      xx = m.xx; xy = m.xy; xz = m.xz;
      yx = m.yx; yy = m.yy; yz = m.yz;
      zx = m.zx; zy = m.zy; zz = m.zz;
      one = sat(64'sd1 <<< QFR_FRAC_BITS);
      tr = sat(sat(xx + yy) + zz);
      if (tr >= 0) begin
         s = root_of(sat(tr + one));
         q.w = word_type'(half_root(s));
         q.x = word_type'(quotient(sat(zy - yz), s));
         q.y = word_type'(quotient(sat(xz - zx), s));
         q.z = word_type'(quotient(sat(yx - xy), s));
      end else if (xx > yy && xx > zz) begin
         s = root_of(sat(sat(sat(one + xx) - yy) - zz));
         q.x = word_type'(half_root(s));
         q.y = word_type'(quotient(sat(yx + xy), s));
         q.z = word_type'(quotient(sat(xz + zx), s));
         q.w = word_type'(quotient(sat(zy - yz), s));
      end else if (yy > zz) begin
         s = root_of(sat(sat(sat(one + yy) - xx) - zz));
         q.y = word_type'(half_root(s));
         q.x = word_type'(quotient(sat(yx + xy), s));
         q.z = word_type'(quotient(sat(zy + yz), s));
         q.w = word_type'(quotient(sat(xz - zx), s));
      end else begin
         s = root_of(sat(sat(sat(one + zz) - xx) - yy));
         q.z = word_type'(half_root(s));
         q.x = word_type'(quotient(sat(xz + zx), s));
         q.y = word_type'(quotient(sat(zy + yz), s));
         q.w = word_type'(quotient(sat(yx - xy), s));
      end
      return q;
   endfunction
endpackage

// ===== verif/qfr_checker.sv =====
`timescale 1ns / 1ps
// qfr_checker: watches both channels, predicts each quaternion, compares in order
// depends on qfr_tb_pkg and the channel interfaces
module qfr_checker
   import qfr_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   qfr_req_if          req_chan,
   qfr_rsp_if          rsp_chan,
   output int          fail_count,
   output int          pending_quats
);
   quat_type expected_quats[$];

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_quats = expected_quats.size();

   always @(posedge clock) begin
      matrix_type m;
      quat_type q;
      if (reset) begin
         fail_count = 0;
      end else begin
         // predict on each accepted request
         if (req_chan.valid && req_chan.ready) begin
            m.xx = req_chan.r0c0; m.xy = req_chan.r0c1; m.xz = req_chan.r0c2;
            m.yx = req_chan.r1c0; m.yy = req_chan.r1c1; m.yz = req_chan.r1c2;
            m.zx = req_chan.r2c0; m.zy = req_chan.r2c1; m.zz = req_chan.r2c2;
            expected_quats.push_back(predict_quat(m));
         end
         // compare each accepted response with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_quats.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               q = expected_quats.pop_front();
               if (rsp_chan.quat_x !== q.x) report_mismatch("quat_x", rsp_chan.quat_x, q.x);
               if (rsp_chan.quat_y !== q.y) report_mismatch("quat_y", rsp_chan.quat_y, q.y);
               if (rsp_chan.quat_z !== q.z) report_mismatch("quat_z", rsp_chan.quat_z, q.z);
               if (rsp_chan.quat_w !== q.w) report_mismatch("quat_w", rsp_chan.quat_w, q.w);
            end
         end
      end
   end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives matrices into quat_from_rotation_matrix with bursty traffic
// depends on qfr_pkg, qfr_tb_pkg, qfr_if and qfr_checker
module testbench;
   import qfr_pkg::*;
   import qfr_tb_pkg::*;

   localparam int LATENCY = 80;
   localparam int IDLE_LIMIT = 5000;
   localparam word_type ONE = word_type'(64'sd1 <<< QFR_FRAC_BITS);
   localparam word_type HALF = word_type'(64'sd1 <<< (QFR_FRAC_BITS - 1));

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_quats;
   int   idle_cycles;
   logic stall_mode;

   qfr_req_if req_chan ();
   qfr_rsp_if rsp_chan ();

   quat_from_rotation_matrix dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   qfr_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_quats (pending_quats)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: alternates phases of free flow and random stalls
   always @(posedge clock) begin
      if (reset) begin
         stall_mode     <= 1'b0;
         rsp_chan.ready <= 1'b1;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
         rsp_chan.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: return word_type'($urandom);
         1: return word_type'(WMAX);
         2: return word_type'(WMIN);
         3: return word_type'($urandom_range(0, 2 * ONE)) - ONE;
         4: return word_type'(0);
         default: return word_type'($urandom_range(0, 2 * HALF)) - HALF;
      endcase
   endfunction

   function automatic matrix_type diag(word_type a, word_type b, word_type c);
      matrix_type m;
      m = '{default: '0};
      m.xx = a; m.yy = b; m.zz = c;
      return m;
   endfunction

   // send one request, holding it until accepted
   task automatic send_matrix(matrix_type m);
      req_chan.valid <= 1'b1;
      req_chan.r0c0 <= m.xx; req_chan.r0c1 <= m.xy; req_chan.r0c2 <= m.xz;
      req_chan.r1c0 <= m.yx; req_chan.r1c1 <= m.yy; req_chan.r1c2 <= m.yz;
      req_chan.r2c0 <= m.zx; req_chan.r2c1 <= m.zy; req_chan.r2c2 <= m.zz;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random matrix: mostly diagonals shaped for each root case, some noise
   function automatic matrix_type rand_matrix();
      matrix_type m;
      m.xx = rand_word(); m.xy = rand_word(); m.xz = rand_word();
      m.yx = rand_word(); m.yy = rand_word(); m.yz = rand_word();
      m.zx = rand_word(); m.zy = rand_word(); m.zz = rand_word();
      case ($urandom_range(0, 4))
         0: begin m.xx = -HALF; m.yy = -HALF; m.zz = word_type'($urandom_range(0, ONE)); end
         1: begin m.xx = word_type'($urandom_range(0, ONE)); m.yy = -ONE; m.zz = -HALF; end
         2: begin m.xx = -ONE; m.yy = word_type'($urandom_range(0, ONE)); m.zz = -ONE; end
         3: begin m.xx = HALF; m.yy = HALF; m.zz = word_type'($urandom_range(0, ONE)); end
         default: ;
      endcase
      return m;
   endfunction

   initial begin
      matrix_type m;
      req_chan.valid = 1'b0;
      {req_chan.r0c0, req_chan.r0c1, req_chan.r0c2} = '0;
      {req_chan.r1c0, req_chan.r1c1, req_chan.r1c2} = '0;
      {req_chan.r2c0, req_chan.r2c1, req_chan.r2c2} = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, each root case, ties, extremes
      send_matrix(diag(ONE, ONE, ONE));
      send_matrix(diag(ONE, -ONE, -ONE));
      send_matrix(diag(-ONE, ONE, -ONE));
      send_matrix(diag(-ONE, -ONE, ONE));
      send_matrix(diag(-HALF, -HALF, -HALF));
      send_matrix(diag(-HALF, -HALF, -ONE));
      send_matrix(diag(-ONE, -HALF, -HALF));
      send_matrix(diag(word_type'(WMIN), word_type'(WMIN), word_type'(WMIN)));
      send_matrix(diag(word_type'(WMAX), word_type'(WMAX), word_type'(WMAX)));
      send_matrix(diag(word_type'(WMAX), word_type'(WMIN), word_type'(WMIN)));
      send_matrix(diag(-ONE, word_type'(WMAX), word_type'(WMIN)));
      send_matrix(diag(word_type'(WMIN), word_type'(WMIN), ONE));
      send_matrix(diag(-ONE, -ONE, -ONE));
      send_matrix(diag(word_type'(-3 * HALF), -ONE, -ONE));
      m = '{default: word_type'(WMAX)};
      m.xx = -ONE; m.yy = -ONE; m.zz = -HALF;
      send_matrix(m);
      m = '{default: word_type'(WMIN)};
      send_matrix(m);
      m = '{default: word_type'(WMAX)};
      send_matrix(m);
      m = diag(ONE, ONE, ONE);
      m.zy = word_type'(WMAX); m.yz = word_type'(WMIN); m.xz = word_type'(WMIN);
      m.zx = word_type'(WMAX); m.yx = word_type'(WMAX); m.xy = word_type'(WMIN);
      send_matrix(m);
      m = diag(word_type'(-1), word_type'(0), word_type'(0));
      send_matrix(m);
      m = '{default: word_type'(32'h5555_5555)};
      send_matrix(m);
      m = '{default: word_type'(32'hAAAA_AAAA)};
      send_matrix(m);

      // hold off until every response has come back
      idle_gap(1);
      while (pending_quats != 0) @(posedge clock);

      // random bursts with gaps
      for (int n = 0; n < 400;) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst && n < 400; k++, n++) send_matrix(rand_matrix());
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
         if (n > 200 && n < 230) begin
            idle_gap(1);
            while (pending_quats != 0) @(posedge clock);
         end
      end
      idle_gap(1);

      // drain, then let the pipeline settle
      while (pending_quats != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0 && pending_quats == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/qfr_pkg.sv
src/qfr_if.sv
src/quat_from_rotation_matrix.sv
verif/qfr_tb_if.sv
verif/qfr_checker.sv
verif/testbench.sv
